// File: design/hdf_pkg.sv
// Package with the shared constants, types and helper function of the body deframer.
`timescale 1ns / 1ps

package hdf_pkg;

    localparam int SIZE_BITS = 32;
    localparam int LEN_W     = 32;
    localparam int CNT_W     = (SIZE_BITS > LEN_W) ? SIZE_BITS : LEN_W;
    localparam int MODE_W    = 3;
    localparam int ERR_W     = 3;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [MODE_W-1:0] MODE_CHUNKED = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FIXED   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLOSE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_EMPTY   = 3'd3;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    typedef enum logic [3:0] {
        PH_SIZE,
        PH_EXT,
        PH_SIZE_LF,
        PH_DATA,
        PH_TRL_CR,
        PH_TRL_LF,
        PH_FIXED,
        PH_CLOSE,
        PH_EMPTY,
        PH_UNDET,
        PH_IDLE
    } t_phase;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE,
        ERR_FOLD,
        ERR_SIZE,
        ERR_UNDET,
        ERR_TRUNC
    } t_err;

    typedef struct packed {
        logic              arm;
        logic [MODE_W-1:0] framing_mode;
        logic [LEN_W-1:0]  body_length;
    } t_cfg_ctrl;

    typedef struct packed {
        logic [7:0]       body_byte;
        logic             body_valid;
        logic             body_done;
        logic [ERR_W-1:0] error_code;
    } t_result;

    // Returns {is_hex_digit, digit_value}.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        case (c) inside
            [8'h30:8'h39]: res = {1'b1, 4'(c - 8'h30)};
            [8'h61:8'h66]: res = {1'b1, 4'(c - 8'h57)};
            [8'h41:8'h46]: res = {1'b1, 4'(c - 8'h37)};
            default:       res = 5'd0;
        endcase
        return res;
    endfunction

endpackage

// File: design/hdf_if.sv
// Valid/ready channel interfaces for body stream beats and result beats.
`timescale 1ns / 1ps

interface hdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_end;

    modport source (output valid, output in_byte, output stream_end, input ready);
    modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface hdf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] body_byte;
    logic       body_valid;
    logic       body_done;
    logic [2:0] error_code;

    modport source (output valid, output body_byte, output body_valid, output body_done,
                    output error_code, input ready);
    modport sink   (input valid, input body_byte, input body_valid, input body_done,
                    input error_code, output ready);
endinterface

// File: design/hdf_apb_regs.sv
// APB configuration registers holding the framing mode and the fixed body length.
`timescale 1ns / 1ps

module hdf_apb_regs
    import hdf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg_ctrl         o_cfg
);

    logic [MODE_W-1:0] r_mode;
    logic [LEN_W-1:0]  r_len;
    logic              w_wr;
    logic              w_sel_len;

    assign w_wr      = psel && penable && pwrite;
    assign w_sel_len = paddr[2];
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CHUNKED;
            r_len  <= '0;
        end else if (w_wr) begin
            if (w_sel_len) begin
                r_len <= pwdata[LEN_W-1:0];
            end else begin
                r_mode <= pwdata[MODE_W-1:0];
            end
        end
    end

    always_comb begin
        o_cfg.arm          = w_wr;
        o_cfg.framing_mode = (w_wr && !w_sel_len) ? pwdata[MODE_W-1:0] : r_mode;
        o_cfg.body_length  = (w_wr && w_sel_len) ? pwdata[LEN_W-1:0] : r_len;
        prdata             = w_sel_len ? r_len : {{(APB_DW-MODE_W){1'b0}}, r_mode};
    end

endmodule

// File: design/hdf_engine.sv
// Framing state machine that turns one registered stream beat into one result.
`timescale 1ns / 1ps

module hdf_engine
    import hdf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg_ctrl  i_cfg,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    output t_result    o_res
);

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_rem, n_rem;
    logic             r_seen, n_seen;
    logic             r_bad, n_bad;
    logic             r_final, n_final;
    t_err             w_err;
    logic [4:0]       w_hex;
    logic             w_ovf;

    assign w_hex = hex_decode(i_byte);
    assign w_ovf = |r_rem[CNT_W-1:SIZE_BITS-4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE;
            r_rem   <= '0;
            r_seen  <= 1'b0;
            r_bad   <= 1'b0;
            r_final <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_rem   <= n_rem;
            r_seen  <= n_seen;
            r_bad   <= n_bad;
            r_final <= n_final;
        end
    end

    always_comb begin
        n_phase          = r_phase;
        n_rem            = r_rem;
        n_seen           = r_seen;
        n_bad            = r_bad;
        n_final          = r_final;
        w_err            = ERR_NONE;
        o_res.body_byte  = 8'd0;
        o_res.body_valid = 1'b0;
        o_res.body_done  = 1'b0;
        if (i_cfg.arm) begin
            n_rem   = '0;
            n_seen  = 1'b0;
            n_bad   = 1'b0;
            n_final = 1'b0;
            case (i_cfg.framing_mode)
                MODE_CHUNKED: n_phase = PH_SIZE;
                MODE_FIXED: begin
                    n_rem   = CNT_W'(i_cfg.body_length);
                    n_phase = (i_cfg.body_length == '0) ? PH_EMPTY : PH_FIXED;
                end
                MODE_CLOSE:   n_phase = PH_CLOSE;
                MODE_EMPTY:   n_phase = PH_EMPTY;
                default:      n_phase = PH_UNDET;
            endcase
        end else if (i_step) begin
            if (i_end) begin
                case (r_phase)
                    PH_IDLE:            ;
                    PH_CLOSE, PH_EMPTY: o_res.body_done = 1'b1;
                    PH_UNDET:           w_err = ERR_UNDET;
                    default:            w_err = ERR_TRUNC;
                endcase
                n_phase = PH_IDLE;
            end else begin
                case (r_phase)
                    PH_SIZE: begin
                        if (w_hex[4]) begin
                            n_seen = 1'b1;
                            if (!r_bad) begin
                                if (w_ovf) begin
                                    n_bad = 1'b1;
                                end else begin
                                    n_rem = {r_rem[CNT_W-5:0], w_hex[3:0]};
                                end
                            end
                        end else if (i_byte == CH_SEMI) begin
                            n_phase = PH_EXT;
                        end else if (i_byte == CH_CR) begin
                            n_phase = PH_SIZE_LF;
                        end else if (i_byte == CH_LF) begin
                            w_err = ERR_FOLD;
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                    PH_EXT: begin
                        if (i_byte == CH_CR) begin
                            n_phase = PH_SIZE_LF;
                        end else if (i_byte == CH_LF) begin
                            w_err = ERR_FOLD;
                        end
                    end
                    PH_SIZE_LF: begin
                        if (i_byte != CH_LF) begin
                            w_err = ERR_FOLD;
                        end else if (!r_seen || r_bad) begin
                            w_err = ERR_SIZE;
                        end else if (r_rem == '0) begin
                            n_final = 1'b1;
                            n_phase = PH_TRL_CR;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        o_res.body_byte  = i_byte;
                        o_res.body_valid = 1'b1;
                        n_rem            = r_rem - CNT_W'(1);
                        if (r_rem == CNT_W'(1)) begin
                            n_phase = PH_TRL_CR;
                        end
                    end
                    PH_TRL_CR: begin
                        if (i_byte == CH_CR) begin
                            n_phase = PH_TRL_LF;
                        end else begin
                            w_err = ERR_FOLD;
                        end
                    end
                    PH_TRL_LF: begin
                        if (i_byte != CH_LF) begin
                            w_err = ERR_FOLD;
                        end else if (r_final) begin
                            o_res.body_done = 1'b1;
                            n_phase         = PH_IDLE;
                        end else begin
                            n_rem   = '0;
                            n_seen  = 1'b0;
                            n_bad   = 1'b0;
                            n_phase = PH_SIZE;
                        end
                    end
                    PH_FIXED: begin
                        o_res.body_byte  = i_byte;
                        o_res.body_valid = 1'b1;
                        n_rem            = r_rem - CNT_W'(1);
                        if (r_rem == CNT_W'(1)) begin
                            o_res.body_done = 1'b1;
                            n_phase         = PH_IDLE;
                        end
                    end
                    PH_CLOSE: begin
                        o_res.body_byte  = i_byte;
                        o_res.body_valid = 1'b1;
                    end
                    PH_EMPTY: begin
                        o_res.body_done = 1'b1;
                        n_phase         = PH_IDLE;
                    end
                    PH_UNDET: begin
                        w_err   = ERR_UNDET;
                        n_phase = PH_IDLE;
                    end
                    default: ;
                endcase
                if (w_err != ERR_NONE) begin
                    n_phase = PH_IDLE;
                end
            end
        end
        o_res.error_code = w_err;
    end

    a_err_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_cfg.arm && w_err != ERR_NONE) |=> (r_phase == PH_IDLE))
        else $error("phase did not go idle after an error beat");

    a_done_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.body_done |-> (w_err == ERR_NONE))
        else $error("body completed together with an error");

    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA || r_phase == PH_FIXED) |-> (r_rem != '0))
        else $error("data phase entered with a zero byte count");

endmodule

// File: design/http_body_deframer_core.sv
// Top level of the body deframer: input register, framing engine, result register, APB port.
//
//   channel  | dir | beat moves                               | accepted when
//   i_in     | in  | in_byte, stream_end                      | valid && ready
//   o_out    | out | body_byte, body_valid, body_done, error  | valid && ready
//   APB      | in  | framing_mode (0x0), body_length (0x4)    | psel && penable && pwrite
//
// One beat is taken every cycle unless the result stalls; it moves from the input register
// to the result register. The framing state updates once per beat, as the beat advances.
// Reset is synchronous and active low; it selects chunked mode with zero length.
// A stalled result holds in the output register while one more beat waits in the input
// register; a write to either configuration register re-arms the framing state.
`timescale 1ns / 1ps

module http_body_deframer_core
    import hdf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    hdf_in_if.sink            i_in,
    hdf_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg_ctrl  w_cfg;
    t_result    w_res;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    logic       r_out_valid;
    t_result    r_out;
    logic       w_advance;
    logic       w_take;

    hdf_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    hdf_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_step  (w_advance),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .o_res   (w_res)
    );

    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign w_take     = i_in.valid && i_in.ready;
    assign i_in.ready = i_rst_n && (!r_in_valid || w_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_byte <= i_in.in_byte;
            r_in_end  <= i_in.stream_end;
        end
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.body_byte  = r_out.body_byte;
    assign o_out.body_valid = r_out.body_valid;
    assign o_out.body_done  = r_out.body_done;
    assign o_out.error_code = r_out.error_code;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_byte) && $stable(r_in_end)))
        else $error("held input beat was lost or changed");

endmodule
